// File: rtl/core/tlpa_pkg.sv
// Shared types and constants of the tagged line pool allocator.
// Holds payload structs, line entry layout, outcome and register codes.
// No dependencies.
`timescale 1ns / 1ps

package tlpa_pkg;

  localparam int PoolDepthDef = 256;
  localparam int LineShift    = 6;
  localparam int GenW         = 6;
  localparam int LinesW       = 9;
  localparam int CfgIdxW      = 8;
  localparam int OutIdxW      = 8;

  localparam logic [GenW-1:0] LastGen = 6'd63;

  localparam logic [CfgIdxW-1:0] CFG_POOL_BASE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINES     = 8'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_USED = 2'd1,
    ST_DEAD = 2'd2
  } line_status_e;

  typedef enum logic [2:0] {
    OUT_ALLOC      = 3'd0,
    OUT_FREED      = 3'd1,
    OUT_EXHAUSTED  = 3'd2,
    OUT_RANGE      = 3'd3,
    OUT_MISALIGNED = 3'd4,
    OUT_NOT_USED   = 3'd5
  } outcome_e;

  typedef struct packed {
    line_status_e    status;
    logic [GenW-1:0] gen;
  } line_t;

  typedef struct packed {
    logic        command;
    logic [63:0] free_address;
  } in_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [OutIdxW-1:0] line_index;
    logic [GenW-1:0]    generation;
    logic [63:0]        tagged_ref;
  } out_t;

endpackage

// File: rtl/core/tlpa_line_ram.sv
// Line table memory: status and generation of every pool line.
// One write port, one read port with registered read data; uses tlpa_pkg.
`timescale 1ns / 1ps

module tlpa_line_ram
  import tlpa_pkg::*;
#(
  parameter int Depth = PoolDepthDef,
  parameter int AddrW = $clog2(PoolDepthDef)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  line_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output line_t            rdata_o
);

  line_t mem [Depth];
  line_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tlpa_ctrl.sv
// Sequencer of the allocator: clearing pass, next-fit scan, free checks.
// Drives the write port and read port of the line table; uses tlpa_pkg.
`timescale 1ns / 1ps

module tlpa_ctrl
  import tlpa_pkg::*;
#(
  parameter int PoolDepth = PoolDepthDef,
  parameter int IdxW      = $clog2(PoolDepthDef),
  parameter int CntW      = $clog2(PoolDepthDef + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  in_t             in_data_i,
  output logic            idle_o,
  input  logic [63:0]     pool_base_i,
  input  logic [CntW-1:0] lines_i,
  output logic            res_valid_o,
  output out_t            res_o,
  input  logic            res_ack_i,
  output logic            ram_we_o,
  output logic [IdxW-1:0] ram_waddr_o,
  output line_t           ram_wdata_o,
  output logic [IdxW-1:0] ram_raddr_o,
  input  line_t           ram_rdata_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FSUB  = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_FRD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [IdxW-1:0] cursor_q, cursor_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_q, n_d;
  logic [63:0]     addr_q, addr_d;
  logic [63:0]     off_q, off_d;
  out_t            res_q, res_d;
  logic            issue;
  logic            found;
  logic [63:0]     top_off;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx,
                                               input logic [CntW-1:0] n);
    logic [CntW-1:0] inc;
    inc = CntW'(idx) + CntW'(1);
    if (inc == n) begin
      return '0;
    end
    return IdxW'(inc);
  endfunction

  assign issue   = (cnt_q != n_q);
  assign found   = chk_vld_q && (ram_rdata_i.status == ST_FREE);
  assign top_off = 64'(n_q - CntW'(1)) << LineShift;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cursor_d    = cursor_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    addr_d      = addr_q;
    off_d       = off_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = chk_idx_q;
    ram_wdata_o = '0;
    ram_raddr_o = idx_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '{status: ST_FREE, gen: '0};
        clr_d       = clr_q + IdxW'(1);
        if (clr_q == IdxW'(PoolDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d = in_data_i.free_address;
          n_d    = lines_i;
          cnt_d  = '0;
          idx_d  = (CntW'(cursor_q) < lines_i) ? cursor_q : '0;
          state_d = (in_data_i.command == CMD_FREE) ? S_FSUB : S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_d = next_idx(idx_q, n_q);
          cnt_d = cnt_q + CntW'(1);
        end
        chk_vld_d = issue;
        chk_idx_d = idx_q;
        if (found) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = chk_idx_q;
          ram_wdata_o = '{status: ST_USED, gen: ram_rdata_i.gen};
          cursor_d    = next_idx(chk_idx_q, n_q);
          res_d.outcome    = OUT_ALLOC;
          res_d.line_index = OutIdxW'(chk_idx_q);
          res_d.generation = ram_rdata_i.gen;
          res_d.tagged_ref = (pool_base_i + (64'(chk_idx_q) << LineShift))
                             | 64'(ram_rdata_i.gen);
          chk_vld_d = 1'b0;
          state_d   = S_DONE;
        end else if (!chk_vld_q && !issue) begin
          res_d         = '0;
          res_d.outcome = OUT_EXHAUSTED;
          state_d       = S_DONE;
        end
      end
      S_FSUB: begin
        off_d   = addr_q - pool_base_i;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        res_d = '0;
        if (off_q > top_off) begin
          res_d.outcome = OUT_RANGE;
          state_d       = S_DONE;
        end else if (off_q[LineShift-1:0] != '0) begin
          res_d.outcome = OUT_MISALIGNED;
          state_d       = S_DONE;
        end else begin
          ram_raddr_o = off_q[LineShift +: IdxW];
          chk_idx_d   = off_q[LineShift +: IdxW];
          state_d     = S_FRD;
        end
      end
      S_FRD: begin
        res_d = '0;
        if (ram_rdata_i.status != ST_USED) begin
          res_d.outcome = OUT_NOT_USED;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = chk_idx_q;
          if (ram_rdata_i.gen == LastGen) begin
            ram_wdata_o = '{status: ST_DEAD, gen: ram_rdata_i.gen};
          end else begin
            ram_wdata_o = '{status: ST_FREE, gen: ram_rdata_i.gen + GenW'(1)};
          end
          res_d.outcome    = OUT_FREED;
          res_d.line_index = OutIdxW'(chk_idx_q);
          res_d.generation = ram_rdata_i.gen;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cursor_q  <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cursor_q  <= cursor_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    n_q       <= n_d;
    addr_q    <= addr_d;
    off_q     <= off_d;
    res_q     <= res_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_we_o)
    else $error("line table written outside an operation");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= n_q && n_q != '0))
    else $error("scan ran past the managed lines");

  a_free_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRD && ram_we_o) |-> (ram_rdata_i.status == ST_USED))
    else $error("free wrote back a line that was not in use");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && found) |=> (state_q == S_DONE && res_q.outcome == OUT_ALLOC))
    else $error("allocation hit did not finish");

endmodule

// File: rtl/core/tagged_line_pool_allocator.sv
// Top level of the tagged line pool allocator: registers, output beat buffer.
// Instantiates tlpa_ctrl and tlpa_line_ram; uses tlpa_pkg.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Allocate scans from the next-fit cursor until a free line is found or all lines_in_use
// lines are examined, which reports an exhausted pool. One line table read a cycle.
// Free steps: subtract, range/alignment check and table read, status check and write
// back, hand-off; a range or alignment error skips the table read and the write back.
// After reset a clearing pass over all POOL_DEPTH lines holds in_stall_o high.
// A finished beat waits in the output register; a new item is taken meanwhile.
// Hand-off holds while the output register carries a stalled beat.
`timescale 1ns / 1ps

module tagged_line_pool_allocator
  import tlpa_pkg::*;
#(
  parameter int POOL_DEPTH = PoolDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int IdxW = $clog2(POOL_DEPTH);
  localparam int CntW = $clog2(POOL_DEPTH + 1);
  localparam int CmpW = (CntW > LinesW) ? CntW : LinesW;

  logic [63:0]       pool_base_q, pool_base_d;
  logic [LinesW-1:0] lines_q, lines_d;
  logic [CmpW-1:0]   lines_ext;
  logic [CntW-1:0]   lines_eff;
  logic              out_valid_q, out_valid_d;
  out_t              out_q;
  logic              ctrl_idle;
  logic              res_valid;
  out_t              res;
  logic              res_ack;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  line_t             ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  line_t             ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pool_base_d = pool_base_q;
    lines_d     = lines_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE: pool_base_d = cfg_data_i;
        CFG_LINES:     lines_d     = cfg_data_i[LinesW-1:0];
        default: ;
      endcase
    end
  end

  assign lines_ext = CmpW'(lines_q);

  always_comb begin
    if (lines_ext == '0) begin
      lines_eff = CntW'(1);
    end else if (lines_ext > CmpW'(POOL_DEPTH)) begin
      lines_eff = CntW'(POOL_DEPTH);
    end else begin
      lines_eff = CntW'(lines_ext);
    end
  end

  assign res_ack = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ack) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      lines_q     <= LinesW'(256);
      out_valid_q <= 1'b0;
    end else begin
      pool_base_q <= pool_base_d;
      lines_q     <= lines_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = !ctrl_idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  tlpa_ctrl #(
    .PoolDepth (POOL_DEPTH),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .idle_o      (ctrl_idle),
    .pool_base_i (pool_base_q),
    .lines_i     (lines_eff),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tlpa_line_ram #(
    .Depth (POOL_DEPTH),
    .AddrW (IdxW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: verif/tagged_line_pool_allocator_tb.sv
// Self-checking bench for tagged_line_pool_allocator: directed and random
// allocate/free beats with idling on both channels, checked against an inline model.
// Depends on tlpa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tagged_line_pool_allocator_tb;
  import tlpa_pkg::*;

  localparam int unsigned LINE_SLOTS = PoolDepthDef;
  localparam logic [63:0] LINE_BYTES = 64'd1 << LineShift;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 130;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_t               out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0]        cfg_data_i;

  line_status_e       status_m [LINE_SLOTS];
  logic [GenW-1:0]    gen_m [LINE_SLOTS];
  int unsigned        cursor_m;
  logic [63:0]        base_m;
  logic [LinesW-1:0]  lines_m;

  out_t               pending_outcomes [$];
  int unsigned        mismatch_count;
  int unsigned        cycle_count;
  int unsigned        gap_odds;
  int unsigned        stall_odds;
  int unsigned        hold_ticket;
  int unsigned        hold_served;

  tagged_line_pool_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned live_lines();
    if (lines_m == 0) return 1;
    if (lines_m > LINE_SLOTS) return LINE_SLOTS;
    return lines_m;
  endfunction

  function automatic logic [63:0] line_addr(int unsigned idx);
    return base_m + 64'(idx) * LINE_BYTES;
  endfunction

  function automatic int pick_used_line(int unsigned n);
    int unsigned start;
    int unsigned k;
    start = $urandom_range(0, n - 1);
    for (k = 0; k < n; k++) begin
      if (status_m[(start + k) % n] == ST_USED) return (start + k) % n;
    end
    return -1;
  endfunction

  function automatic out_t allocator_outcome(in_t item);
    out_t        r;
    int unsigned n;
    int unsigned idx;
    int unsigned k;
    logic [63:0] offset;
    r = '0;
    n = live_lines();
    if (item.command == CMD_ALLOC) begin
      r.outcome = OUT_EXHAUSTED;
      idx = (cursor_m < n) ? cursor_m : 0;
      for (k = 0; k < n; k++) begin
        if (status_m[idx] == ST_FREE) begin
          status_m[idx] = ST_USED;
          cursor_m = (idx + 1) % n;
          r.outcome = OUT_ALLOC;
          r.line_index = idx[OutIdxW-1:0];
          r.generation = gen_m[idx];
          r.tagged_ref = line_addr(idx) | 64'(gen_m[idx]);
          break;
        end
        idx = (idx + 1) % n;
      end
    end else begin
      offset = item.free_address - base_m;
      if (offset > 64'(n - 1) * LINE_BYTES) begin
        r.outcome = OUT_RANGE;
      end else if (offset % LINE_BYTES != 0) begin
        r.outcome = OUT_MISALIGNED;
      end else begin
        idx = int'(offset / LINE_BYTES);
        if (status_m[idx] != ST_USED) begin
          r.outcome = OUT_NOT_USED;
        end else begin
          r.outcome = OUT_FREED;
          r.line_index = idx[OutIdxW-1:0];
          r.generation = gen_m[idx];
          if (gen_m[idx] == LastGen) begin
            status_m[idx] = ST_DEAD;
          end else begin
            gen_m[idx] = gen_m[idx] + 1'b1;
            status_m[idx] = ST_FREE;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("beat with nothing pending", out_data_o.tagged_ref, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_data_o.outcome !== want.outcome)
          flag_mismatch("outcome", out_data_o.outcome, want.outcome);
        if (out_data_o.line_index !== want.line_index)
          flag_mismatch("line_index", out_data_o.line_index, want.line_index);
        if (out_data_o.generation !== want.generation)
          flag_mismatch("generation", out_data_o.generation, want.generation);
        if (out_data_o.tagged_ref !== want.tagged_ref)
          flag_mismatch("tagged_ref", out_data_o.tagged_ref, want.tagged_ref);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin : receiver
    int unsigned n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != hold_served) begin
        hold_served++;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(in_t item);
    int unsigned n;
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_outcomes.push_back(allocator_outcome(item));
  endtask

  task automatic send_alloc();
    in_t item;
    item.command = CMD_ALLOC;
    item.free_address = rand64();
    send_item(item);
  endtask

  task automatic send_free(logic [63:0] addr);
    in_t item;
    item.command = CMD_FREE;
    item.free_address = addr;
    send_item(item);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_POOL_BASE) base_m = data;
    else if (idx == CFG_LINES) lines_m = data[LinesW-1:0];
  endtask

  task automatic random_item();
    int unsigned n;
    int unsigned pick;
    int          line;
    n = live_lines();
    pick = $urandom_range(0, 99);
    line = pick_used_line(n);
    if (pick < 45 || (pick < 85 && line < 0)) begin
      send_alloc();
    end else if (pick < 85) begin
      send_free(line_addr(line));
    end else begin
      case ($urandom_range(0, 4))
        0: send_free(rand64());
        1: send_free(base_m + 64'($urandom_range(0, n * 64 - 1)));
        2: send_free(line_addr($urandom_range(0, n - 1)));
        3: send_free(line_addr(n));
        default: send_free(base_m - 64'($urandom_range(1, 64)));
      endcase
    end
  endtask

  task automatic test_directed();
    gap_odds = 20;
    stall_odds = 10;
    send_free(64'd0);
    send_alloc();
    send_free(64'd1);
    send_free('1);
    send_free(64'(LINE_SLOTS - 1) * LINE_BYTES);
    send_free(64'(LINE_SLOTS) * LINE_BYTES);
    send_free(64'd0);
    send_alloc();
    send_alloc();
    write_reg(CFG_LINES, 64'd2);
    send_alloc();
    send_alloc();
    write_reg(CFG_LINES, 64'd0);
    write_reg(CFG_POOL_BASE, ~(LINE_BYTES - 1));
    send_free(base_m);
    send_free(base_m + LINE_BYTES);
    send_free(base_m - LINE_BYTES);
    send_alloc();
    write_reg(CFG_LINES, 64'h1FF);
    write_reg(CFG_POOL_BASE, 64'd0);
    write_reg(8'd2, rand64());
    write_reg(8'hFF, rand64());
    write_reg(CfgIdxW'($urandom_range(3, 254)), rand64());
    send_free(64'(LINE_SLOTS) * LINE_BYTES);
    send_free(64'(LINE_SLOTS - 1) * LINE_BYTES);
    send_alloc();
  endtask

  task automatic test_line_retirement();
    gap_odds = 10;
    stall_odds = 10;
    write_reg(CFG_LINES, 64'd1);
    write_reg(CFG_POOL_BASE, rand64() & ~(LINE_BYTES - 1));
    while (status_m[0] != ST_DEAD) begin
      if (status_m[0] == ST_USED) send_free(line_addr(0));
      else send_alloc();
    end
    send_alloc();
    send_free(line_addr(0));
  endtask

  task automatic test_backpressure();
    int unsigned k;
    gap_odds = 0;
    stall_odds = 0;
    write_reg(CFG_LINES, 64'd8);
    write_reg(CFG_POOL_BASE, rand64() & ~(LINE_BYTES - 1));
    hold_ticket++;
    for (k = 0; k < 40; k++) random_item();
  endtask

  task automatic test_random_phases();
    int unsigned p;
    int unsigned k;
    for (p = 0; p < PHASES; p++) begin
      gap_odds = (p == PHASES - 1) ? 0 : $urandom_range(0, 3) * 10;
      stall_odds = (p == PHASES - 1) ? 0 : $urandom_range(0, 3) * 10;
      case (p)
        0: write_reg(CFG_LINES, 64'($urandom_range(1, 4)));
        1: write_reg(CFG_LINES, 64'($urandom_range(1, LINE_SLOTS)));
        2: write_reg(CFG_LINES, 64'(LINE_SLOTS));
        3: write_reg(CFG_LINES, 64'($urandom_range(LINE_SLOTS + 1, 511)));
        4: write_reg(CFG_LINES, 64'd0);
        default: write_reg(CFG_LINES, 64'($urandom_range(2, 32)));
      endcase
      if (p == PHASES - 1) write_reg(CFG_POOL_BASE, rand64());
      else write_reg(CFG_POOL_BASE, rand64() & ~(LINE_BYTES - 1));
      if ($urandom_range(0, 1)) write_reg(CfgIdxW'($urandom_range(2, 255)), rand64());
      for (k = 0; k < PHASE_ITEMS; k++) random_item();
    end
  endtask

  initial begin : run
    int unsigned k;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    mismatch_count = 0;
    cycle_count = 0;
    gap_odds = 0;
    stall_odds = 0;
    hold_ticket = 0;
    hold_served = 0;
    for (k = 0; k < LINE_SLOTS; k++) begin
      status_m[k] = ST_FREE;
      gen_m[k] = '0;
    end
    cursor_m = 0;
    base_m = '0;
    lines_m = LinesW'(LINE_SLOTS);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_line_retirement();
    test_backpressure();
    test_random_phases();

    settle();
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tlpa_pkg.sv
rtl/core/tlpa_line_ram.sv
rtl/core/tlpa_ctrl.sv
rtl/core/tagged_line_pool_allocator.sv
verif/tagged_line_pool_allocator_tb.sv
